// File: rtl/core/mna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mna_pkg
// Shared types and constants for the MIDI note arpeggiator.
// ----------------------------------------------------------------------------
package mna_pkg;

    localparam int NOTE_RANGE_DEF = 128;
    localparam int BLOCK_MAX_DEF  = 4096;

    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int NS_W   = 13;
    localparam int OFF_W  = 12;
    localparam int DUR_W  = 16;
    localparam int SUM_W  = 17;   // elapsed + clamped block length

    localparam logic [DUR_W-1:0] DUR_RESET = 16'd7200;
    localparam logic [VEL_W-1:0] VEL_ON    = 7'd127;
    localparam logic [VEL_W-1:0] VEL_OFF   = 7'd0;

    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  velocity;
        logic [NS_W-1:0]   block_samples;
    } t_in_item;

    typedef struct packed {
        logic              is_note_on;
        logic [NOTE_W-1:0] out_note;
        logic [VEL_W-1:0]  out_velocity;
        logic [OFF_W-1:0]  sample_offset;
        logic              last_event;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic held_set;
        logic held_clr;
        logic tick_load;
        logic emit_off;
        logic emit_on;
        logic div_start;
        logic div_sel_elap;   // 0: step index, 1: elapsed counter
        logic step_wr;
        logic scan_step;
        logic elap_wr;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fire;
        logic snd_vld;
        logic have_notes;
        logic out_free;
        logic div_done;
        logic scan_found;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/core/mna_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mna_rem
// Restoring remainder unit, one dividend bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module mna_rem
    import mna_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [DUR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DUR_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_d;

    logic [DUR_W:0]   trial;
    logic [DUR_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[SUM_W-1]};
        if (trial >= {1'b0, r_d}) begin
            n_rem = DUR_W'(trial - {1'b0, r_d});
        end else begin
            n_rem = trial[DUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: rtl/core/mna_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mna_dpath
// Held-note set, step/sounding state, tick arithmetic, note scan, output reg.
// ----------------------------------------------------------------------------
module mna_dpath
    import mna_pkg::*;
#(
    parameter int NOTE_RANGE = NOTE_RANGE_DEF,
    parameter int BLOCK_MAX  = BLOCK_MAX_DEF
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire t_in_item         i_in_item,
    input  wire logic             i_cfg_we,
    input  wire logic [DUR_W-1:0] i_cfg_data,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item
);

    localparam int NW = $clog2(NOTE_RANGE);
    localparam int CW = $clog2(NOTE_RANGE + 1);
    localparam logic [SUM_W-1:0] BLOCK_MAX_W = SUM_W'(BLOCK_MAX);

    logic [NOTE_RANGE-1:0] r_held;
    logic [CW-1:0]         r_count;
    logic [NW-1:0]         r_step;
    logic                  r_snd_vld;
    logic [NOTE_W-1:0]     r_snd_note;
    logic [DUR_W-1:0]      r_elapsed;
    logic [DUR_W-1:0]      r_dur;
    logic [DUR_W-1:0]      r_d;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_fire;
    logic [OFF_W-1:0]      r_off;
    logic [NW-1:0]         r_idx;
    logic [NW-1:0]         r_seen;
    logic                  r_full;
    t_out_item             r_out;

    logic              in_range;
    logic [NW-1:0]     note_idx;
    logic              held_bit;
    logic [DUR_W-1:0]  d_eff;
    logic [NS_W-1:0]   ns_sat;
    logic [SUM_W-1:0]  sum;
    logic signed [17:0] off_a;
    logic signed [17:0] off_lim;
    logic signed [17:0] off_c;
    logic              scan_bit;
    logic              found;
    logic              out_free;
    logic              div_done;
    logic [DUR_W-1:0]  div_rem;
    logic [SUM_W-1:0]  div_dividend;
    logic [DUR_W-1:0]  div_divisor;

    assign in_range = {1'b0, i_in_item.note_number} < 8'(NOTE_RANGE);
    assign note_idx = i_in_item.note_number[NW-1:0];
    assign held_bit = r_held[note_idx];

    // tick arithmetic on the pre-tick counter
    always_comb begin
        d_eff = (r_dur == '0) ? DUR_W'(1) : r_dur;
        if ({4'b0, i_in_item.block_samples} > BLOCK_MAX_W) begin
            ns_sat = BLOCK_MAX_W[NS_W-1:0];
        end else begin
            ns_sat = i_in_item.block_samples;
        end
        sum     = {4'b0, ns_sat} + {1'b0, r_elapsed};
        off_a   = $signed({2'b0, d_eff}) - $signed({2'b0, r_elapsed});
        off_lim = $signed({5'b0, ns_sat}) - 18'sd1;
        off_c   = (off_a > off_lim) ? off_lim : off_a;
        if (off_c < 18'sd0) begin
            off_c = 18'sd0;
        end
    end

    assign scan_bit = r_held[r_idx];
    assign found    = scan_bit && (r_seen == r_step);
    assign out_free = !r_full || !i_out_stall;

    assign div_dividend = i_cmd.div_sel_elap ? r_sum : (SUM_W'(r_step) + SUM_W'(1));
    assign div_divisor  = i_cmd.div_sel_elap ? r_d   : DUR_W'(r_count);

    mna_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_count   <= '0;
            r_step    <= '0;
            r_snd_vld <= 1'b0;
            r_snd_note <= '0;
            r_elapsed <= '0;
            r_dur     <= DUR_RESET;
            r_full    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dur <= i_cfg_data;
            end
            if (i_cmd.held_set && in_range && !held_bit) begin
                r_held[note_idx] <= 1'b1;
                r_count          <= r_count + 1'b1;
            end
            if (i_cmd.held_clr && in_range && held_bit) begin
                r_held[note_idx] <= 1'b0;
                r_count          <= r_count - 1'b1;
            end
            if (i_cmd.step_wr) begin
                r_step <= div_rem[NW-1:0];
            end
            if (i_cmd.elap_wr) begin
                r_elapsed <= div_rem;
            end
            if (i_cmd.scan_step && found) begin
                r_snd_note <= NOTE_W'(r_idx);
            end
            if (i_cmd.emit_off) begin
                r_snd_vld <= 1'b0;
            end else if (i_cmd.emit_on) begin
                r_snd_vld <= 1'b1;
            end
            if (i_cmd.emit_off || i_cmd.emit_on) begin
                r_full <= 1'b1;
            end else if (r_full && !i_out_stall) begin
                r_full <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_load) begin
            r_d    <= d_eff;
            r_sum  <= sum;
            r_fire <= sum >= {1'b0, d_eff};
            r_off  <= off_c[OFF_W-1:0];
        end
        if (i_cmd.step_wr) begin
            r_idx  <= '0;
            r_seen <= '0;
        end else if (i_cmd.scan_step && !found) begin
            r_idx <= r_idx + 1'b1;
            if (scan_bit) begin
                r_seen <= r_seen + 1'b1;
            end
        end
        if (i_cmd.emit_off) begin
            r_out.is_note_on    <= 1'b0;
            r_out.out_note      <= r_snd_note;
            r_out.out_velocity  <= VEL_OFF;
            r_out.sample_offset <= r_off;
            r_out.last_event    <= (r_count == '0);
        end else if (i_cmd.emit_on) begin
            r_out.is_note_on    <= 1'b1;
            r_out.out_note      <= r_snd_note;
            r_out.out_velocity  <= VEL_ON;
            r_out.sample_offset <= r_off;
            r_out.last_event    <= 1'b1;
        end
    end

    assign o_sts.fire       = r_fire;
    assign o_sts.snd_vld    = r_snd_vld;
    assign o_sts.have_notes = (r_count != '0);
    assign o_sts.out_free   = out_free;
    assign o_sts.div_done   = div_done;
    assign o_sts.scan_found = found;

    assign o_out_valid = r_full;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// File: rtl/core/mna_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mna_ctrl
// Sequencer: decodes an accepted item and walks a tick through its steps.
// ----------------------------------------------------------------------------
module mna_ctrl
    import mna_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd_code,
    input  wire logic       i_vel_zero,
    output logic            o_in_stall,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_OFF       = 8'b0000_0010,
        S_STEP_GO   = 8'b0000_0100,
        S_STEP_WAIT = 8'b0000_1000,
        S_SCAN      = 8'b0001_0000,
        S_ON        = 8'b0010_0000,
        S_ELAP_GO   = 8'b0100_0000,
        S_ELAP_WAIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd_code)
                        CMD_NOTE_ON: begin
                            o_cmd.held_set = !i_vel_zero;
                            o_cmd.held_clr = i_vel_zero;
                        end
                        CMD_NOTE_OFF: o_cmd.held_clr = 1'b1;
                        CMD_TICK: begin
                            o_cmd.tick_load = 1'b1;
                            n_state         = S_OFF;
                        end
                        default: ;
                    endcase
                end
            end
            S_OFF: begin
                if (!i_sts.fire) begin
                    n_state = S_ELAP_GO;
                end else if (!i_sts.snd_vld || i_sts.out_free) begin
                    o_cmd.emit_off = i_sts.snd_vld;
                    n_state = i_sts.have_notes ? S_STEP_GO : S_ELAP_GO;
                end
            end
            S_STEP_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.step_wr = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_found) begin
                    n_state = S_ON;
                end
            end
            S_ON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_on = 1'b1;
                    n_state       = S_ELAP_GO;
                end
            end
            S_ELAP_GO: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_elap = 1'b1;
                n_state            = S_ELAP_WAIT;
            end
            S_ELAP_WAIT: begin
                o_cmd.div_sel_elap = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.elap_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/midi_note_arpeggiator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_arpeggiator
// Ascending-order arpeggiator over a set of held MIDI notes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_stall     i_in_item  (t_in_item)
//  out      source     o_out_valid / i_out_stall   o_out_item (t_out_item)
//  cfg      sink       i_cfg_we                    i_cfg_data (note duration)
//
//  Note commands update the held set without leaving the idle state.
//  A tick runs one remainder pass when no step fires, and when a step
//  fires with notes held, two passes and a one-note-per-cycle held-set scan.
//  Synchronous active-low reset clears note set, count, step and elapsed.
//  One item is in flight at a time; an output stall holds the sequencer only
//  when a new event must be loaded into the full output register.
// ----------------------------------------------------------------------------
module midi_note_arpeggiator
    import mna_pkg::*;
#(
    parameter int NOTE_RANGE = NOTE_RANGE_DEF,
    parameter int BLOCK_MAX  = BLOCK_MAX_DEF
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_we,
    input  wire logic [DUR_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd_code (i_in_item.cmd),
        .i_vel_zero (i_in_item.velocity == '0),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mna_dpath #(
        .NOTE_RANGE (NOTE_RANGE),
        .BLOCK_MAX  (BLOCK_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_on_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_note_on) |-> (o_out_item.out_velocity == VEL_ON))
        else $error("note-on item without full velocity");

    a_off_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.is_note_on) |-> (o_out_item.out_velocity == VEL_OFF))
        else $error("note-off item with nonzero velocity");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.cmd == CMD_TICK)) |=> o_in_stall)
        else $error("input not stalled after tick accepted");

endmodule
`default_nettype wire

// File: bench/midi_note_arpeggiator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_arpeggiator_tb
// Self-checking bench for the up-mode arpeggiator. A directed table covers
// reset state, block and duration extremes and the note-set corner cases.
// A flood of ticks over a full note set runs against a long output hold-off.
// Random note/tick traffic then runs over several step lengths. Events not
// in typed rows are scored against an in-bench note-set and step-counter model.
// ----------------------------------------------------------------------------
module midi_note_arpeggiator_tb;
    import mna_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYC = 200;   // covers the longest firing tick
    localparam int HOLD_CYC   = 600;
    localparam int RAND_ITEMS = 1250;
    localparam int IDLE_PCT   = 22;
    localparam int MAX_PRINT  = 40;
    localparam int TIMEOUT_NS = 40_000_000;
    localparam t_out_item NO_EV = '0;

    typedef struct packed {
        logic             is_cfg;
        logic [DUR_W-1:0] cfg_val;
        t_in_item         item;
        logic             typed;
        logic [1:0]       n_ev;
        t_out_item        ev0;
        t_out_item        ev1;
    } dir_row_t;

    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_item  = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_we   = 1'b0;
    logic [DUR_W-1:0] i_cfg_data = '0;

    // arpeggiator model state
    logic [NOTE_RANGE_DEF-1:0] note_set   = '0;
    int                        note_cnt   = 0;
    logic [NOTE_W-1:0]         arp_pos    = '0;
    logic                      voice_on   = 1'b0;
    logic [NOTE_W-1:0]         voice_note = '0;
    int                        sample_pos = 0;
    logic [DUR_W-1:0]          step_len   = DUR_RESET;

    t_out_item tick_events[$];
    t_out_item pending_events[$];
    dir_row_t  dir_tab[$];

    int   err_cnt = 0;
    int   fed_cnt = 0;
    int   rx_hold = 0;
    logic no_idle = 1'b0;

    midi_note_arpeggiator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINT) begin
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    function automatic t_out_item mk_ev(input logic on, input int note, input int ofs,
                                        input logic last);
        t_out_item ev;
        ev.is_note_on    = on;
        ev.out_note      = NOTE_W'(note);
        ev.out_velocity  = on ? VEL_ON : VEL_OFF;
        ev.sample_offset = OFF_W'(ofs);
        ev.last_event    = last;
        return ev;
    endfunction

    // k-th held note, counting up from note 0
    function automatic logic [NOTE_W-1:0] nth_held(input int k);
        int seen;
        int n;
        seen = 0;
        for (n = 0; n < NOTE_RANGE_DEF; n++) begin
            if (note_set[n]) begin
                if (seen == k) return NOTE_W'(n);
                seen++;
            end
        end
        return '0;
    endfunction

    // Advances the model by one accepted item; events land in tick_events.
    function automatic void arp_model_step(input t_in_item it);
        logic [1:0] op;
        int         len;
        int         blk;
        int         ofs;
        t_out_item  ev;
        tick_events.delete();
        op = it.cmd;
        if (op == CMD_NOTE_ON && it.velocity == '0) op = CMD_NOTE_OFF;
        case (op)
            CMD_NOTE_ON: begin
                if (!note_set[it.note_number]) begin
                    note_set[it.note_number] = 1'b1;
                    note_cnt++;
                end
            end
            CMD_NOTE_OFF: begin
                if (note_set[it.note_number]) begin
                    note_set[it.note_number] = 1'b0;
                    note_cnt--;
                end
            end
            CMD_TICK: begin
                len = (step_len == '0) ? 1 : int'(step_len);
                blk = (it.block_samples > BLOCK_MAX_DEF) ? BLOCK_MAX_DEF
                                                         : int'(it.block_samples);
                if (sample_pos + blk >= len) begin
                    // goes negative once the step was shortened under the counter
                    ofs = len - sample_pos;
                    if (ofs > blk - 1) ofs = blk - 1;
                    if (ofs < 0) ofs = 0;
                    if (voice_on) begin
                        tick_events.push_back(mk_ev(1'b0, voice_note, ofs, 1'b0));
                        voice_on = 1'b0;
                    end
                    if (note_cnt > 0) begin
                        arp_pos    = NOTE_W'((int'(arp_pos) + 1) % note_cnt);
                        voice_note = nth_held(arp_pos);
                        voice_on   = 1'b1;
                        tick_events.push_back(mk_ev(1'b1, voice_note, ofs, 1'b0));
                    end
                    if (tick_events.size() > 0) begin
                        ev = tick_events.pop_back();
                        ev.last_event = 1'b1;
                        tick_events.push_back(ev);
                    end
                end
                sample_pos = (sample_pos + blk) % len;
            end
            default: ;
        endcase
    endfunction

    // mostly block sizes that make steps fire often for the given step length
    function automatic logic [NS_W-1:0] pick_block(input int len);
        int r;
        r = $urandom_range(99);
        if (r < 65) return NS_W'($urandom_range((len > BLOCK_MAX_DEF) ? BLOCK_MAX_DEF : len, 0));
        if (r < 75) return NS_W'($urandom_range(8191, BLOCK_MAX_DEF + 1));
        if (r < 85) return NS_W'($urandom_range(1, 0));
        return NS_W'($urandom_range(8191, 0));
    endfunction

    function automatic t_in_item rand_item(input int len);
        t_in_item it;
        int       r;
        r = $urandom_range(99);
        it.note_number   = ($urandom_range(99) < 70) ? NOTE_W'($urandom_range(72, 48))
                                                     : NOTE_W'($urandom);
        it.velocity      = ($urandom_range(9) == 0) ? '0 : VEL_W'($urandom);
        it.block_samples = NS_W'($urandom);
        if (r < 45) begin
            it.cmd           = CMD_TICK;
            it.block_samples = pick_block(len);
        end else if (r < 72) begin
            it.cmd = CMD_NOTE_ON;
        end else if (r < 95) begin
            it.cmd = CMD_NOTE_OFF;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic dir_row_t row_cfg(input logic [DUR_W-1:0] v);
        dir_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic dir_row_t row_note(input logic [1:0] c, input int n, input int v);
        dir_row_t r;
        r                  = '0;
        r.item.cmd         = c;
        r.item.note_number = NOTE_W'(n);
        r.item.velocity    = VEL_W'(v);
        return r;
    endfunction

    function automatic dir_row_t row_tick(input int ns, input int n_ev,
                                          input t_out_item e0, input t_out_item e1);
        dir_row_t r;
        r                    = '0;
        r.item.cmd           = CMD_TICK;
        r.item.block_samples = NS_W'(ns);
        r.typed              = 1'b1;
        r.n_ev               = 2'(n_ev);
        r.ev0                = e0;
        r.ev1                = e1;
        return r;
    endfunction

    task automatic idle_cycle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // returns at the accepting edge; caller drives or drops valid at the next negedge
    task automatic drive_item(input t_in_item it);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        arp_model_step(it);
    endtask

    task automatic send_checked(input t_in_item it);
        drive_item(it);
        foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
        fed_cnt++;
    endtask

    task automatic drain_events();
        idle_cycle();
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_step_len(input logic [DUR_W-1:0] v);
        drain_events();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        step_len = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Full note set, step length one, output held off while ticks keep coming.
    task automatic flood_with_hold();
        t_in_item it;
        int       k;
        set_step_len(16'd1);
        for (k = 0; k < NOTE_RANGE_DEF; k++) begin
            it             = rand_item(1);
            it.cmd         = CMD_NOTE_ON;
            it.note_number = NOTE_W'(k * 37);
            it.velocity    = VEL_W'($urandom_range(127, 1));
            send_checked(it);
        end
        rx_hold = HOLD_CYC;
        repeat (80) begin
            it               = rand_item(1);
            it.cmd           = CMD_TICK;
            it.block_samples = NS_W'($urandom_range(BLOCK_MAX_DEF, 1));
            send_checked(it);
        end
        // sender holds back until every event is out
        drain_events();
        for (k = 0; k < NOTE_RANGE_DEF; k++) begin
            it             = rand_item(1);
            it.cmd         = CMD_NOTE_OFF;
            it.note_number = NOTE_W'(k * 53);
            if ($urandom_range(1) == 0) begin
                it.cmd      = CMD_NOTE_ON;
                it.velocity = '0;
            end
            send_checked(it);
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : score_events
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event, note", o_out_item.out_note, -1);
            end else begin
                want = pending_events.pop_front();
                if (o_out_item.is_note_on != want.is_note_on)
                    report_mismatch("is_note_on", o_out_item.is_note_on, want.is_note_on);
                if (o_out_item.out_note != want.out_note)
                    report_mismatch("out_note", o_out_item.out_note, want.out_note);
                if (o_out_item.out_velocity != want.out_velocity)
                    report_mismatch("out_velocity", o_out_item.out_velocity,
                                    want.out_velocity);
                if (o_out_item.sample_offset != want.sample_offset)
                    report_mismatch("sample_offset", o_out_item.sample_offset,
                                    want.sample_offset);
                if (o_out_item.last_event != want.last_event)
                    report_mismatch("last_event", o_out_item.last_event, want.last_event);
            end
        end
    end

    initial begin : run_stimulus
        dir_row_t         row;
        logic [DUR_W-1:0] dur_plan[$];
        logic [DUR_W-1:0] plan;
        int               phase;
        int               len;
        int               n_items;

        dir_tab = '{
            row_tick(0, 0, NO_EV, NO_EV),                   // empty block
            row_tick(8191, 0, NO_EV, NO_EV),                // saturates to BLOCK_MAX
            row_tick(4096, 0, NO_EV, NO_EV),                // step with nothing held
            row_note(CMD_NOTE_ON, 0, 127),
            row_note(CMD_NOTE_ON, 127, 1),
            row_note(CMD_NOTE_ON, 127, 1),                  // repeated note on
            row_note(CMD_NOTE_ON, 60, 0),                   // velocity zero, not held
            row_note(CMD_NOTE_OFF, 5, 127),                 // not held
            row_note(CMD_UNUSED, 64, 127),                  // must not add note 64
            row_tick(4096, 0, NO_EV, NO_EV),
            row_tick(4096, 1, mk_ev(1'b1, 127, 2112, 1'b1), NO_EV),
            row_cfg(16'd0),                                 // zero duration acts as one
            row_tick(0, 2, mk_ev(1'b0, 127, 0, 1'b0), mk_ev(1'b1, 0, 0, 1'b1)),
            row_note(CMD_NOTE_OFF, 0, 64),                  // sounding note released
            row_tick(1, 2, mk_ev(1'b0, 0, 0, 1'b0), mk_ev(1'b1, 127, 0, 1'b1)),
            row_note(CMD_NOTE_ON, 127, 0),
            row_tick(1, 1, mk_ev(1'b0, 127, 0, 1'b1), NO_EV),
            row_tick(1, 0, NO_EV, NO_EV),
            row_cfg(16'hFFFF),
            row_note(CMD_NOTE_ON, 64, 127),
            row_tick(4096, 0, NO_EV, NO_EV)
        };
        dur_plan = '{16'd4096, 16'd1, 16'd0, 16'd65535, 16'd2, 16'd97, 16'd7200, 16'd1000};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.is_cfg) begin
                set_step_len(row.cfg_val);
            end else begin
                drive_item(row.item);
                if (row.typed) begin
                    if (row.n_ev > 0) pending_events.push_back(row.ev0);
                    if (row.n_ev > 1) pending_events.push_back(row.ev1);
                end else begin
                    foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
                end
            end
        end

        flood_with_hold();

        phase = 0;
        while (fed_cnt < RAND_ITEMS) begin
            if (phase < dur_plan.size()) begin
                plan = dur_plan[phase];
            end else begin
                plan = ($urandom_range(3) == 0) ? DUR_W'($urandom)
                                                : DUR_W'($urandom_range(2000, 1));
            end
            set_step_len(plan);
            no_idle = (phase == 4);
            len     = (plan == '0) ? 1 : int'(plan);
            n_items = (len > 16384) ? 60 : 120;
            repeat (n_items) begin
                if (fed_cnt >= RAND_ITEMS) break;
                while (!no_idle && $urandom_range(99) < IDLE_PCT) idle_cycle();
                send_checked(rand_item(len));
            end
            phase++;
        end
        no_idle = 1'b0;

        drain_events();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
